/* src/vlm_pkg.sv */
// Shared types and constants for the vibration level meter.
// No dependencies; imported by every module under src.
package vlm_pkg;

    localparam int AXIS_W    = 16;            // one accelerometer axis
    localparam int SQ_W      = 32;            // x*x + y*y + z*z
    localparam int ROOT_W    = 16;            // floor square root
    localparam int STEP_W    = 4;             // counts ROOT_W / AXIS_W serial steps
    localparam int Q_W       = 32;            // Q16.16 average and deviation
    localparam int FRAC_W    = 16;
    localparam int GAIN_W    = 16;
    localparam int ACC_W     = 35;            // signed serial product accumulator
    localparam int SUM_W     = 38;            // running deviation sum
    localparam int IN_DATA_W = 48;            // three packed axes
    localparam int OUT_DATA_W = 32;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd6554;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_UPDATE,
        ST_DIVIDE,
        ST_HOLD
    } vlm_state_t;

endpackage

/* src/vibration_level_meter.sv */
// Top level of the vibration level meter: sequencer, window sum and output register.
// Uses vlm_pkg, vlm_sumsq, vlm_isqrt, vlm_ema and vlm_div.
//
//   channel   | direction | beats carry
//   ----------+-----------+---------------------------------------------
//   s_axis    | in        | one three-axis sample, restart flag in tuser
//   m_axis    | out       | window mean deviation, Q16.16
//   cfg       | in        | smoothing gain write, Q0.16
//
// An item runs its phases in turn before the next transfer is accepted: idle, the serial squares,
// the root, then the gain multiply, update and deviation.
// The item that closes a window adds the serial division by WINDOW.
// Reset clears the average, sum and count and sets the gain to about 0.1; no sweep is needed.
// A result waits in the output register; the next sample is taken meanwhile,
// and the sequencer stalls only if a new result finds that register still full.
module vibration_level_meter #(
    parameter int WINDOW = 20
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [vlm_pkg::GAIN_W-1:0]          cfg_wr_data,    // smoothing_gain
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [vlm_pkg::IN_DATA_W-1:0]       s_axis_tdata,   // accel_x, accel_y, accel_z
    input  logic                                s_axis_tuser,   // restart
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [vlm_pkg::OUT_DATA_W-1:0]      m_axis_tdata    // mean_deviation
);
    import vlm_pkg::*;

    localparam int CNT_W = $clog2(WINDOW + 1);

    vlm_state_t            state_reg;
    vlm_state_t            state_next;
    logic [GAIN_W-1:0]     gain_reg;
    logic [GAIN_W-1:0]     gain_next;
    logic                  restart_reg;
    logic                  restart_next;
    logic [SUM_W-1:0]      sum_reg;
    logic [SUM_W-1:0]      sum_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;

    logic                  in_xfer;
    logic                  out_free;
    logic                  sq_start;
    logic                  sq_done;
    logic [SQ_W-1:0]       sum_sq;
    logic                  root_start;
    logic                  root_done;
    logic [ROOT_W-1:0]     root;
    logic                  ema_start;
    logic                  ema_done;
    logic [Q_W-1:0]        dev;
    logic                  div_start;
    logic                  div_done;
    logic [OUT_DATA_W-1:0] quotient;
    logic                  out_load;
    logic [SUM_W-1:0]      sum_base;
    logic [CNT_W-1:0]      cnt_base;
    logic [CNT_W-1:0]      cnt_inc;
    logic                  window_end;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;

    // restart drops the old sum and count before this sample lands
    assign sum_base   = restart_reg ? '0 : sum_reg;
    assign cnt_base   = restart_reg ? '0 : cnt_reg;
    assign cnt_inc    = cnt_base + 1'b1;
    assign window_end = cnt_inc >= CNT_W'(WINDOW);

    vlm_sumsq u_sumsq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (sq_start),
        .x      (s_axis_tdata[AXIS_W-1:0]),
        .y      (s_axis_tdata[2*AXIS_W-1:AXIS_W]),
        .z      (s_axis_tdata[3*AXIS_W-1:2*AXIS_W]),
        .done   (sq_done),
        .sum_sq (sum_sq)
    );

    vlm_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (sum_sq),
        .done     (root_done),
        .root     (root)
    );

    vlm_ema u_ema (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (ema_start),
        .restart (restart_reg),
        .mag     (root),
        .gain    (gain_reg),
        .done    (ema_done),
        .dev     (dev)
    );

    vlm_div #(
        .WINDOW (WINDOW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_base + SUM_W'(dev)),
        .done     (div_done),
        .quotient (quotient)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                    state_next = ST_SQUARE;
            end
            ST_SQUARE:
            begin
                if (sq_done)
                    state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (root_done)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (ema_done)
                    state_next = window_end ? ST_DIVIDE : ST_IDLE;
            end
            ST_DIVIDE:
            begin
                if (div_done)
                    state_next = out_free ? ST_IDLE : ST_HOLD;
            end
            ST_HOLD:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        sq_start      = 1'b0;
        root_start    = 1'b0;
        ema_start     = 1'b0;
        div_start     = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                sq_start      = s_axis_tvalid;
            end
            ST_SQUARE:
                root_start = sq_done;
            ST_ROOT:
                ema_start = root_done;
            ST_UPDATE:
                div_start = ema_done && window_end;
            ST_DIVIDE:
                out_load = div_done && out_free;
            ST_HOLD:
                out_load = out_free;
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        gain_next      = cfg_wr_en ? cfg_wr_data : gain_reg;
        restart_next   = in_xfer ? s_axis_tuser : restart_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        if (ema_done && state_reg == ST_UPDATE)
        begin
            sum_next = window_end ? '0 : sum_base + SUM_W'(dev);
            cnt_next = window_end ? '0 : cnt_inc;
        end
        out_valid_next = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);
        out_data_next  = out_load ? quotient : out_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            gain_reg      <= GAIN_RESET;
            restart_reg   <= 1'b0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gain_reg      <= gain_next;
            restart_reg   <= restart_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    a_count_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg < CNT_W'(WINDOW))
        else $error("sample count reached the window length");

    a_div_clears_window: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> (cnt_reg == '0 && sum_reg == '0))
        else $error("window not cleared when its mean was started");

    a_square_done_in_state: assert property (@(posedge clk) disable iff (!rst_n)
        sq_done |-> state_reg == ST_SQUARE)
        else $error("square unit finished outside its phase");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> m_axis_tvalid)
        else $error("result load did not raise the output valid");

endmodule

/* src/vlm_sumsq.sv */
// Bit-serial sum of squares of three signed axes, one multiplier bit per cycle.
// Depends on vlm_pkg.
module vlm_sumsq (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [vlm_pkg::AXIS_W-1:0] x,
    input  logic signed [vlm_pkg::AXIS_W-1:0] y,
    input  logic signed [vlm_pkg::AXIS_W-1:0] z,
    output logic                              done,
    output logic [vlm_pkg::SQ_W-1:0]          sum_sq
);
    import vlm_pkg::*;

    logic [AXIS_W-1:0] mp_reg [3];
    logic [AXIS_W-1:0] mp_next [3];
    logic [SQ_W-1:0]   mc_reg [3];
    logic [SQ_W-1:0]   mc_next [3];
    logic [SQ_W-1:0]   acc_reg;
    logic [SQ_W-1:0]   acc_next;
    logic [STEP_W-1:0] cnt_reg;
    logic [STEP_W-1:0] cnt_next;
    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [AXIS_W-1:0] mag [3];
    logic [SQ_W-1:0]   partial;

    function automatic logic [AXIS_W-1:0] abs_axis(input logic signed [AXIS_W-1:0] v);
        return v[AXIS_W-1] ? AXIS_W'(-v) : AXIS_W'(v);
    endfunction

    assign mag[0] = abs_axis(x);
    assign mag[1] = abs_axis(y);
    assign mag[2] = abs_axis(z);

    assign partial = (mp_reg[0][0] ? mc_reg[0] : '0)
                   + (mp_reg[1][0] ? mc_reg[1] : '0)
                   + (mp_reg[2][0] ? mc_reg[2] : '0);

    always_comb
    begin
        mp_next   = mp_reg;
        mc_next   = mc_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mp_next[i] = mag[i];
                mc_next[i] = SQ_W'(mag[i]);
            end
            acc_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // add the shifted multiplicands whose multiplier bit is set
            acc_next = acc_reg + partial;
            for (int i = 0; i < 3; i++)
            begin
                mp_next[i] = mp_reg[i] >> 1;
                mc_next[i] = mc_reg[i] << 1;
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == STEP_W'(AXIS_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mp_reg  <= mp_next;
        mc_reg  <= mc_next;
        acc_reg <= acc_next;
    end

    assign done   = done_reg;
    assign sum_sq = acc_reg;

endmodule

/* src/vlm_isqrt.sv */
// Digit-serial floor square root, one root bit per cycle (restoring method).
// Depends on vlm_pkg.
module vlm_isqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [vlm_pkg::SQ_W-1:0]   radicand,
    output logic                       done,
    output logic [vlm_pkg::ROOT_W-1:0] root
);
    import vlm_pkg::*;

    localparam int REM_W = ROOT_W + 2;

    logic [SQ_W-1:0]   rad_reg;
    logic [SQ_W-1:0]   rad_next;
    logic [REM_W-1:0]  rem_reg;
    logic [REM_W-1:0]  rem_next;
    logic [ROOT_W-1:0] root_reg;
    logic [ROOT_W-1:0] root_next;
    logic [STEP_W-1:0] cnt_reg;
    logic [STEP_W-1:0] cnt_next;
    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [REM_W+1:0]  pulled;
    logic [REM_W+1:0]  trial;

    // bring down the next two radicand bits and try root*4 + 1
    assign pulled = {rem_reg, rad_reg[SQ_W-1 -: 2]};
    assign trial  = (REM_W + 2)'({root_reg, 2'b01});

    always_comb
    begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next = rad_reg << 2;
            if (pulled >= trial)
            begin
                rem_next  = REM_W'(pulled - trial);
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = REM_W'(pulled);
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == STEP_W'(ROOT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

/* src/vlm_ema.sv */
// Moving average update with a bit-serial gain multiply, then the absolute deviation.
// Holds the Q16.16 average. Depends on vlm_pkg.
module vlm_ema (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       restart,
    input  logic [vlm_pkg::ROOT_W-1:0] mag,
    input  logic [vlm_pkg::GAIN_W-1:0] gain,
    output logic                       done,
    output logic [vlm_pkg::Q_W-1:0]    dev
);
    import vlm_pkg::*;

    localparam int PH_W      = 5;
    localparam int PH_UPDATE = GAIN_W;

    logic [Q_W-1:0]          avg_reg;
    logic [Q_W-1:0]          avg_next;
    logic [Q_W-1:0]          magq_reg;
    logic [Q_W-1:0]          magq_next;
    logic signed [Q_W:0]     diff_reg;
    logic signed [Q_W:0]     diff_next;
    logic [GAIN_W-1:0]       gsh_reg;
    logic [GAIN_W-1:0]       gsh_next;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic [Q_W-1:0]          dev_reg;
    logic [Q_W-1:0]          dev_next;
    logic [PH_W-1:0]         ph_reg;
    logic [PH_W-1:0]         ph_next;
    logic                    busy_reg;
    logic                    busy_next;
    logic                    done_reg;
    logic                    done_next;
    logic [Q_W-1:0]          base;
    logic [Q_W-1:0]          magq_in;
    logic signed [ACC_W-1:0] addend;
    logic signed [ACC_W-1:0] acc_sum;
    logic signed [ACC_W-1:0] avg_sum;

    assign base    = restart ? '0 : avg_reg;
    assign magq_in = {mag, {FRAC_W{1'b0}}};
    assign addend  = gsh_reg[0] ? ACC_W'(diff_reg) : '0;
    assign acc_sum = acc_reg + addend;
    assign avg_sum = $signed({{(ACC_W - Q_W){1'b0}}, avg_reg}) + acc_reg;

    always_comb
    begin
        avg_next  = avg_reg;
        magq_next = magq_reg;
        diff_next = diff_reg;
        gsh_next  = gsh_reg;
        acc_next  = acc_reg;
        dev_next  = dev_reg;
        ph_next   = ph_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            avg_next  = base;
            magq_next = magq_in;
            diff_next = $signed({1'b0, magq_in}) - $signed({1'b0, base});
            gsh_next  = gain;
            acc_next  = '0;
            ph_next   = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            ph_next = ph_reg + 1'b1;
            if (ph_reg < PH_W'(PH_UPDATE))
            begin
                // halve after each add: ends at floor(gain * diff / 2^16)
                acc_next = acc_sum >>> 1;
                gsh_next = gsh_reg >> 1;
            end
            else if (ph_reg == PH_W'(PH_UPDATE))
            begin
                if (avg_sum < 0)
                    avg_next = '0;
                else if (avg_sum[ACC_W-1:Q_W] != '0)
                    avg_next = '1;
                else
                    avg_next = avg_sum[Q_W-1:0];
            end
            else
            begin
                dev_next  = (magq_reg >= avg_reg) ? magq_reg - avg_reg
                                                  : avg_reg - magq_reg;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_reg  <= '0;
            ph_reg   <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            avg_reg  <= avg_next;
            ph_reg   <= ph_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        magq_reg <= magq_next;
        diff_reg <= diff_next;
        gsh_reg  <= gsh_next;
        acc_reg  <= acc_next;
        dev_reg  <= dev_next;
    end

    assign done = done_reg;
    assign dev  = dev_reg;

endmodule

/* src/vlm_div.sv */
// Bit-serial restoring division of the deviation sum by the window length.
// Keeps the low quotient bits. Depends on vlm_pkg.
module vlm_div #(
    parameter int WINDOW = 20
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [vlm_pkg::SUM_W-1:0]      dividend,
    output logic                           done,
    output logic [vlm_pkg::OUT_DATA_W-1:0] quotient
);
    import vlm_pkg::*;

    localparam int REM_W = $clog2(WINDOW + 1);
    localparam int CNT_W = $clog2(SUM_W);

    logic [SUM_W-1:0]      dvd_reg;
    logic [SUM_W-1:0]      dvd_next;
    logic [REM_W-1:0]      rem_reg;
    logic [REM_W-1:0]      rem_next;
    logic [OUT_DATA_W-1:0] quo_reg;
    logic [OUT_DATA_W-1:0] quo_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic                  busy_reg;
    logic                  busy_next;
    logic                  done_reg;
    logic                  done_next;
    logic [REM_W:0]        trial;
    logic                  fits;

    assign trial = {rem_reg, dvd_reg[SUM_W-1]};
    assign fits  = trial >= (REM_W + 1)'(WINDOW);

    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next  = dividend;
            rem_next  = '0;
            quo_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = dvd_reg << 1;
            rem_next = fits ? REM_W'(trial - (REM_W + 1)'(WINDOW)) : REM_W'(trial);
            quo_next = {quo_reg[OUT_DATA_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(SUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
